FILE: rtl/vau_pkg.sv
package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQ_STAGES     = 32;

    typedef logic signed [31:0] word_t;

    localparam word_t W_MAX = 32'sh7fffffff;
    localparam word_t W_MIN = 32'sh80000000;

    // register index taken from paddr[2]
    localparam logic REG_ZERO_THR = 1'b0;
    localparam logic [15:0] ZERO_THR_RST = 16'd1;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_DOT   = 4'd4,
        OP_CROSS = 4'd5,
        OP_LENSQ = 4'd6,
        OP_LEN   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic  clamp;
        word_t val;
    } sat_t;

    typedef struct packed {
        op_t         op;
        word_t [2:0] a;
        word_t [2:0] b;
        word_t       s;
    } req_t;

    typedef struct packed {
        op_t         op;
        word_t [2:0] a;
        word_t       s;
        sat_t  [2:0] vec;
        sat_t        sc;
        logic [31:0] len;
    } meta_t;

    function automatic sat_t sat66(input logic signed [65:0] v);
        sat_t r;
        if (v[65:31] == '0 || v[65:31] == '1)
        begin
            r.clamp = 1'b0;
            r.val   = v[31:0];
        end
        else
        begin
            r.clamp = 1'b1;
            r.val   = v[65] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

endpackage

FILE: rtl/vau_if.sv
interface vau_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;

    modport source (output valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                    input ready);
    modport sink (input valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  output ready);
endinterface

interface vau_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic [1:0]  status;

    modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
    modport sink (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface

FILE: rtl/vau_lane.sv
module vau_lane #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  vau_pkg::op_t       op,
    input  vau_pkg::word_t     a_i,
    input  vau_pkg::word_t     b_i,
    input  vau_pkg::word_t     a_j,
    input  vau_pkg::word_t     b_k,
    input  vau_pkg::word_t     a_k,
    input  vau_pkg::word_t     b_j,
    input  vau_pkg::word_t     s,
    output logic signed [63:0] prod,
    output vau_pkg::sat_t      vec
);

    vau_pkg::word_t     m0a;
    vau_pkg::word_t     m0b;
    logic signed [63:0] p0_next;
    logic signed [63:0] p1_next;
    logic signed [32:0] as_next;
    logic signed [63:0] p0_reg;
    logic signed [63:0] p1_reg;
    logic signed [32:0] as_reg;
    vau_pkg::op_t       op_reg;
    logic signed [64:0] cr;
    logic signed [64:0] cr_sh;
    logic signed [63:0] sc_sh;
    vau_pkg::sat_t      vec_next;
    vau_pkg::sat_t      vec_reg;

    always_comb
    begin
        case (op)
            vau_pkg::OP_SCALE:
            begin
                m0a = a_i;
                m0b = s;
            end
            vau_pkg::OP_CROSS:
            begin
                m0a = a_j;
                m0b = b_k;
            end
            vau_pkg::OP_DOT:
            begin
                m0a = a_i;
                m0b = b_i;
            end
            default:
            begin
                m0a = a_i;
                m0b = a_i;
            end
        endcase
    end

    assign p0_next = m0a * m0b;
    assign p1_next = a_k * b_j;
    assign as_next = (op == vau_pkg::OP_SUB) ? (33'(a_i) - 33'(b_i)) : (33'(a_i) + 33'(b_i));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            as_reg  <= as_next;
            op_reg  <= op;
            vec_reg <= vec_next;
        end
    end

    // floor of the scaled product is an arithmetic shift
    assign cr    = 65'(p0_reg) - 65'(p1_reg);
    assign cr_sh = cr >>> FRAC_BITS;
    assign sc_sh = p0_reg >>> FRAC_BITS;

    always_comb
    begin
        case (op_reg)
            vau_pkg::OP_ADD,
            vau_pkg::OP_SUB:   vec_next = vau_pkg::sat66(66'(as_reg));
            vau_pkg::OP_SCALE: vec_next = vau_pkg::sat66(66'(sc_sh));
            vau_pkg::OP_CROSS: vec_next = vau_pkg::sat66(66'(cr_sh));
            default:           vec_next = '0;
        endcase
    end

    assign prod = p0_reg;
    assign vec  = vec_reg;

endmodule

FILE: rtl/vau_isqrt.sv
module vau_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [31:0] root
);

    localparam int N = vau_pkg::SQ_STAGES;

    logic [63:0] rem_reg [N];
    logic [63:0] res_reg [N];
    logic [63:0] rin     [N];
    logic [63:0] sin     [N];

    assign rin[0] = din;
    assign sin[0] = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [63:0] BITK = 64'(1) << (62 - 2 * k);
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        if (k > 0)
        begin : g_link
            assign rin[k] = rem_reg[k-1];
            assign sin[k] = res_reg[k-1];
        end

        assign trial = sin[k] + BITK;

        always_comb
        begin
            if (rin[k] >= trial)
            begin
                rem_next = rin[k] - trial;
                res_next = (sin[k] >> 1) + BITK;
            end
            else
            begin
                rem_next = rin[k];
                res_next = sin[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[N-1][31:0];

endmodule

FILE: rtl/vau_div.sv
module vau_div #(
    parameter int N = 48
) (
    input  logic         clk,
    input  logic         en,
    input  logic [N-1:0] dividend,
    input  logic [31:0]  divisor,
    output logic [N-1:0] quo
);

    logic [31:0]  r_reg  [N];
    logic [N-1:0] dq_reg [N];
    logic [31:0]  d_reg  [N];
    logic [31:0]  rin    [N];
    logic [N-1:0] dqin   [N];
    logic [31:0]  din    [N];

    assign rin[0]  = '0;
    assign dqin[0] = dividend;
    assign din[0]  = divisor;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [32:0] sh;
        logic        ge;
        logic [32:0] diff;

        if (k > 0)
        begin : g_link
            assign rin[k]  = r_reg[k-1];
            assign dqin[k] = dq_reg[k-1];
            assign din[k]  = d_reg[k-1];
        end

        // dividend bits shift out the top while quotient bits enter below
        assign sh   = {rin[k], dqin[k][N-1]};
        assign ge   = (sh >= {1'b0, din[k]});
        assign diff = sh - {1'b0, din[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]  <= ge ? diff[31:0] : sh[31:0];
                dq_reg[k] <= {dqin[k][N-2:0], ge};
                d_reg[k]  <= din[k];
            end
        end
    end

    assign quo = dq_reg[N-1];

endmodule

FILE: rtl/vector3_arithmetic_unit.sv
// 3-component vector unit in signed fixed point with FRAC_BITS fraction bits.
// req channel: one item per operation (req_type plus vectors a, b and scalar_in);
// res channel: one item per request, in request order, with the vector, the
// scalar result and a status code (ok, saturated, divide by zero, zero guard).
// Both channels use valid/ready; an item moves when both are high.
// The APB port holds zero_threshold at address 0 (reset value 1); it is read
// back on prdata and should only be written while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. Every
// operation takes the same path: input register, two lane stages (multiplier
// then round and clamp), a 32-stage square root, a (32 + FRAC_BITS)-stage
// restoring divider per lane and the output register, in that order.
// When the receiver stalls while the last pipeline stage holds an item, the
// whole pipeline freezes and req.ready drops; if that stage is empty it still
// shifts by one per cycle.
// Reset clears all valid flags and loads the threshold; no item is lost or
// repeated across a stall.
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vau_req_if.sink     req,
    vau_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SQ   = vau_pkg::SQ_STAGES;
    localparam int DW   = 32 + FRAC_BITS;
    localparam int NSTG = 3 + SQ + DW;

    logic                 en;
    logic [15:0]          thr_reg;
    logic [NSTG-1:0]      vld_reg;
    logic [NSTG-1:0]      vld_next;
    vau_pkg::req_t        s0_next;
    vau_pkg::req_t        s0_reg;
    vau_pkg::req_t        s1_reg;
    vau_pkg::req_t        s2_reg;
    logic signed [63:0]   prod [3];
    vau_pkg::sat_t        lvec [3];
    logic signed [65:0]   sum_next;
    logic signed [65:0]   sum_reg;
    logic signed [65:0]   dsh;
    vau_pkg::meta_t       ma_next;
    vau_pkg::meta_t       meta_a_reg [SQ];
    vau_pkg::meta_t       mb_next;
    vau_pkg::meta_t       meta_b_reg [DW];
    vau_pkg::meta_t       mf;
    logic [31:0]          root;
    logic [31:0]          smag;
    logic                 guard_b;
    logic [31:0]          dsr;
    logic [DW-1:0]        dvd [3];
    logic [DW-1:0]        quo [3];
    logic                 guard_f;
    vau_pkg::sat_t        fv [3];
    vau_pkg::sat_t        fsc;
    vau_pkg::status_t     fst;
    logic                 out_vld_reg;
    vau_pkg::word_t       rx_reg;
    vau_pkg::word_t       ry_reg;
    vau_pkg::word_t       rz_reg;
    vau_pkg::word_t       rs_reg;
    vau_pkg::status_t     st_reg;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == vau_pkg::REG_ZERO_THR) ? {16'b0, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= vau_pkg::ZERO_THR_RST;
        else if (psel && penable && pwrite && paddr[2] == vau_pkg::REG_ZERO_THR)
            thr_reg <= pwdata[15:0];
    end

    // pipeline advance: frozen only when a finished item cannot leave
    assign en        = !(out_vld_reg && !res.ready) || !vld_reg[NSTG-1];
    assign req.ready = en;
    assign vld_next  = {vld_reg[NSTG-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_comb
    begin
        s0_next.op   = vau_pkg::op_t'(req.req_type);
        s0_next.a[0] = req.a_x;
        s0_next.a[1] = req.a_y;
        s0_next.a[2] = req.a_z;
        s0_next.b[0] = req.b_x;
        s0_next.b[1] = req.b_y;
        s0_next.b[2] = req.b_z;
        s0_next.s    = req.scalar_in;
    end

    // lanes: one per vector component
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk  (clk),
            .en   (en),
            .op   (s0_reg.op),
            .a_i  (s0_reg.a[i]),
            .b_i  (s0_reg.b[i]),
            .a_j  (s0_reg.a[J]),
            .b_k  (s0_reg.b[K]),
            .a_k  (s0_reg.a[K]),
            .b_j  (s0_reg.b[J]),
            .s    (s0_reg.s),
            .prod (prod[i]),
            .vec  (lvec[i])
        );
    end

    // merge of the lane products for dot and squared length
    assign sum_next = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
    assign dsh      = sum_reg >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            s1_reg  <= s0_reg;
            s2_reg  <= s1_reg;
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        ma_next.op  = s2_reg.op;
        ma_next.a   = s2_reg.a;
        ma_next.s   = s2_reg.s;
        ma_next.len = '0;
        for (int i = 0; i < 3; i++)
            ma_next.vec[i] = lvec[i];
        case (s2_reg.op)
            vau_pkg::OP_DOT:   ma_next.sc = vau_pkg::sat66(dsh);
            vau_pkg::OP_LENSQ:
            begin
                // sum of squares is never negative
                if (sum_reg[63:31+FRAC_BITS] != '0)
                    ma_next.sc = {1'b1, vau_pkg::W_MAX};
                else
                    ma_next.sc = {1'b0, 1'b0, sum_reg[30+FRAC_BITS:FRAC_BITS]};
            end
            default:           ma_next.sc = '0;
        endcase
    end

    vau_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .din  (sum_reg[63:0]),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_a_reg[0] <= ma_next;
            for (int k = 1; k < SQ; k++)
                meta_a_reg[k] <= meta_a_reg[k-1];
        end
    end

    // divisor select: |scalar| for divide, length for normalize, 1 otherwise or when zero or guarded
    always_comb
    begin
        mb_next     = meta_a_reg[SQ-1];
        mb_next.len = root;
        smag        = mb_next.s[31] ? (~mb_next.s + 32'd1) : mb_next.s;
        guard_b     = (root == '0) || (root < {16'b0, thr_reg});
        case (mb_next.op)
            vau_pkg::OP_DIV:  dsr = (mb_next.s == '0) ? 32'd1 : smag;
            vau_pkg::OP_NORM: dsr = guard_b ? 32'd1 : root;
            default:          dsr = 32'd1;
        endcase
        for (int i = 0; i < 3; i++)
            dvd[i] = {(mb_next.a[i][31] ? (~mb_next.a[i] + 32'd1) : mb_next.a[i]),
                      {FRAC_BITS{1'b0}}};
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vau_div #(.N(DW)) u_div (
            .clk      (clk),
            .en       (en),
            .dividend (dvd[i]),
            .divisor  (dsr),
            .quo      (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_b_reg[0] <= mb_next;
            for (int k = 1; k < DW; k++)
                meta_b_reg[k] <= meta_b_reg[k-1];
        end
    end

    assign mf      = meta_b_reg[DW-1];
    assign guard_f = (mf.len == '0) || (mf.len < {16'b0, thr_reg});

    // final select, sign restore and status
    always_comb
    begin
        logic signed [DW:0] qs [3];
        logic               neg;
        logic               clamp;
        for (int i = 0; i < 3; i++)
        begin
            neg   = (mf.op == vau_pkg::OP_DIV) ? (mf.a[i][31] ^ mf.s[31]) : mf.a[i][31];
            qs[i] = neg ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
            fv[i] = '0;
        end
        fsc   = '0;
        fst   = vau_pkg::ST_OK;
        clamp = 1'b0;
        case (mf.op)
            vau_pkg::OP_ADD,
            vau_pkg::OP_SUB,
            vau_pkg::OP_SCALE,
            vau_pkg::OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    fv[i] = mf.vec[i];
            end
            vau_pkg::OP_DIV:
            begin
                if (mf.s == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (mf.a[i] == '0)
                            fv[i] = '0;
                        else
                            fv[i] = {1'b0, (mf.a[i][31] ? vau_pkg::W_MIN : vau_pkg::W_MAX)};
                    end
                    fst = vau_pkg::ST_DIVZ;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        fv[i] = vau_pkg::sat66(66'(qs[i]));
                end
            end
            vau_pkg::OP_DOT,
            vau_pkg::OP_LENSQ: fsc = mf.sc;
            vau_pkg::OP_LEN:
            begin
                if (mf.len[31])
                    fsc = {1'b1, vau_pkg::W_MAX};
                else
                    fsc = {1'b0, mf.len};
            end
            vau_pkg::OP_NORM:
            begin
                if (guard_f)
                    fst = vau_pkg::ST_ZERO;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        fv[i] = vau_pkg::sat66(66'(qs[i]));
                end
            end
            default: fst = vau_pkg::ST_OK;
        endcase
        clamp = fv[0].clamp || fv[1].clamp || fv[2].clamp || fsc.clamp;
        if (fst == vau_pkg::ST_OK && clamp)
            fst = vau_pkg::ST_SAT;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (!out_vld_reg || res.ready)
            out_vld_reg <= vld_reg[NSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || res.ready)
        begin
            rx_reg <= fv[0].val;
            ry_reg <= fv[1].val;
            rz_reg <= fv[2].val;
            rs_reg <= fsc.val;
            st_reg <= fst;
        end
    end

    assign res.valid      = out_vld_reg;
    assign res.res_x      = rx_reg;
    assign res.res_y      = ry_reg;
    assign res.res_z      = rz_reg;
    assign res.res_scalar = rs_reg;
    assign res.status     = st_reg;

`ifndef SYNTHESIS
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (res.valid && !res.ready))
        else $error("input blocked without an output stall");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready && vld_reg[NSTG-1]) |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_zero_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == vau_pkg::ST_ZERO) |->
        (res.res_x == '0 && res.res_y == '0 && res.res_z == '0 && res.res_scalar == '0))
        else $error("zero guard item carries nonzero data");

    a_divz_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == vau_pkg::ST_DIVZ) |-> res.res_scalar == '0)
        else $error("divide by zero item carries a scalar");
`endif

endmodule

FILE: dv/tb_vector3_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_vector3_arithmetic_unit;

    localparam int FB = vau_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 35 + 32 + FB;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [31:0]      sc;
        vau_pkg::status_t st;
    } vec_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vau_req_if req_ch ();
    vau_res_if res_ch ();

    vector3_arithmetic_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .res(res_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    vec_result_t expected_q[$];
    logic [15:0] zero_thr;
    int mismatches;
    int checked;
    bit rx_quiet;
    bit rx_hold;
    bit tx_quiet;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [63:0] floor_shift(input logic signed [127:0] v);
        logic signed [127:0] q;
        q = v >>> FB;
        return q[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                  inout bit clamped);
        if (v > S32_MAX)
        begin
            clamped = 1'b1;
            return S32_MAX[31:0];
        end
        if (v < S32_MIN)
        begin
            clamped = 1'b1;
            return S32_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // truncating divide of (a << FB) by d
    function automatic logic signed [127:0] div_trunc(input logic signed [31:0] a,
                                                     input logic signed [127:0] d);
        logic signed [127:0] n;
        n = a;
        n = n <<< FB;
        return n / d;
    endfunction

    function automatic vec_result_t predict_vector_op(input logic [3:0] op,
            input logic signed [31:0] a[3], input logic signed [31:0] b[3],
            input logic signed [31:0] s);
        vec_result_t r;
        logic signed [31:0] v[3];
        logic signed [127:0] acc;
        logic [63:0] sq;
        logic [63:0] len;
        bit clamped;
        v = '{0, 0, 0};
        r.sc = 0;
        r.st = vau_pkg::ST_OK;
        clamped = 1'b0;
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq = sq + 64'($signed(64'(a[i])) * $signed(64'(a[i])));
        case (op)
            vau_pkg::OP_ADD, vau_pkg::OP_SUB:
                for (int i = 0; i < 3; i++)
                begin
                    acc = (op == vau_pkg::OP_ADD) ? 128'(a[i]) + 128'(b[i])
                                                  : 128'(a[i]) - 128'(b[i]);
                    v[i] = clamp32(acc, clamped);
                end
            vau_pkg::OP_SCALE:
                for (int i = 0; i < 3; i++)
                    v[i] = clamp32(floor_shift(128'(a[i]) * 128'(s)), clamped);
            vau_pkg::OP_DIV:
                if (s == 0)
                begin
                    for (int i = 0; i < 3; i++)
                        v[i] = a[i] > 0 ? S32_MAX[31:0] : (a[i] < 0 ? S32_MIN[31:0] : 0);
                    r.st = vau_pkg::ST_DIVZ;
                end
                else
                    for (int i = 0; i < 3; i++)
                        v[i] = clamp32(div_trunc(a[i], 128'(s)), clamped);
            vau_pkg::OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc = acc + 128'(a[i]) * 128'(b[i]);
                r.sc = clamp32(floor_shift(acc), clamped);
            end
            vau_pkg::OP_CROSS:
                for (int i = 0; i < 3; i++)
                begin
                    acc = 128'(a[(i + 1) % 3]) * 128'(b[(i + 2) % 3])
                          - 128'(a[(i + 2) % 3]) * 128'(b[(i + 1) % 3]);
                    v[i] = clamp32(floor_shift(acc), clamped);
                end
            vau_pkg::OP_LENSQ:
            begin
                sq = sq >> FB;
                if (sq > 64'(S32_MAX))
                begin
                    clamped = 1'b1;
                    sq = 64'(S32_MAX);
                end
                r.sc = sq[31:0];
            end
            vau_pkg::OP_LEN:
            begin
                len = root_floor(sq);
                if (len > 64'(S32_MAX))
                begin
                    clamped = 1'b1;
                    len = 64'(S32_MAX);
                end
                r.sc = len[31:0];
            end
            vau_pkg::OP_NORM:
            begin
                len = root_floor(sq);
                if (len == 0 || len < 64'(zero_thr))
                    r.st = vau_pkg::ST_ZERO;
                else
                    for (int i = 0; i < 3; i++)
                        v[i] = clamp32(div_trunc(a[i], 128'(len)), clamped);
            end
            default:
                ;
        endcase
        if (clamped && r.st == vau_pkg::ST_OK)
            r.st = vau_pkg::ST_SAT;
        r.x = v[0];
        r.y = v[1];
        r.z = v[2];
        return r;
    endfunction

    task automatic send_request(input logic [3:0] op, input logic signed [31:0] a[3],
                                input logic signed [31:0] b[3],
                                input logic signed [31:0] s);
        while (!tx_quiet && $urandom_range(99) < 8)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= op;
        req_ch.a_x <= a[0];
        req_ch.a_y <= a[1];
        req_ch.a_z <= a[2];
        req_ch.b_x <= b[0];
        req_ch.b_y <= b[1];
        req_ch.b_z <= b[2];
        req_ch.scalar_in <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_q.push_back(predict_vector_op(op, a, b, s));
    endtask

    task automatic write_zero_thr(input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {vau_pkg::REG_ZERO_THR, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        zero_thr = val;
    endtask

    task automatic drain_pipeline();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(9))
            0: return S32_MAX[31:0];
            1: return S32_MIN[31:0];
            2: return 0;
            3: return $urandom_range(2) - 1;
            4, 5: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            6, 7: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int n);
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        logic [3:0] op;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rand_word();
                b[i] = rand_word();
            end
            // unused codes now and then
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                           : 4'($urandom_range(8));
            send_request(op, a, b, rand_word());
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        a = '{S32_MAX[31:0], S32_MIN[31:0], 32'sh0001_0000};
        b = '{S32_MAX[31:0], S32_MIN[31:0], -32'sh0002_0000};
        for (int op = 0; op < 16; op++)
            send_request(4'(op), a, b, 32'sh0001_8000);
        a = '{32'sh0003_0000, -32'sh0004_0000, 0};
        send_request(vau_pkg::OP_DIV, a, b, 0);
        send_request(vau_pkg::OP_DIV, a, b, 32'sh0000_0001);
        send_request(vau_pkg::OP_NORM, a, b, 0);
        send_request(vau_pkg::OP_SCALE, a, b, S32_MIN[31:0]);
        a = '{0, 0, 0};
        send_request(vau_pkg::OP_NORM, a, b, 0);
        a = '{32'sd1, 0, 0};
        send_request(vau_pkg::OP_NORM, a, b, 0);
        a = '{-32'sd1, -32'sd1, -32'sd1};
        send_request(vau_pkg::OP_LEN, a, b, 0);
        send_request(vau_pkg::OP_CROSS, b, a, 0);
        drain_pipeline();
    endtask

    task automatic test_threshold_settings();
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        logic [15:0] thr[4] = '{16'hFFFF, 16'd0, 16'd300, 16'd1};
        b = '{0, 0, 0};
        foreach (thr[t])
        begin
            write_zero_thr(thr[t]);
            for (int k = 0; k < 30; k++)
            begin
                for (int i = 0; i < 3; i++)
                    a[i] = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
                if (k < 3)
                    a = '{32'(k), 0, 0};
                send_request(vau_pkg::OP_NORM, a, b, 0);
            end
            drain_pipeline();
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            send_random(200);
            begin
                repeat (400)
                    @(posedge clk);
                rx_hold = 1'b0;
            end
        join
        drain_pipeline();
    endtask

    task automatic test_random_stream();
        send_random(700);
        // sender pauses until everything is back
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_random(300);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_random(550);
    endtask

    // result checker with random stalls
    always @(posedge clk)
    begin
        vec_result_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item x=%h st=%0d", res_ch.res_x, res_ch.status);
            end
            else
            begin
                e = expected_q.pop_front();
                checked++;
                if (res_ch.res_x !== e.x || res_ch.res_y !== e.y || res_ch.res_z !== e.z
                    || res_ch.res_scalar !== e.sc || res_ch.status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch item %0d: exp %h %h %h %h %0d got %h %h %h %h %0d",
                                 checked, e.x, e.y, e.z, e.sc, e.st, res_ch.res_x,
                                 res_ch.res_y, res_ch.res_z, res_ch.res_scalar,
                                 res_ch.status);
                end
            end
        end
        res_ch.ready <= !rx_hold && (rx_quiet || $urandom_range(99) >= 8);
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.a_x = '0;
        req_ch.a_y = '0;
        req_ch.a_z = '0;
        req_ch.b_x = '0;
        req_ch.b_y = '0;
        req_ch.b_z = '0;
        req_ch.scalar_in = '0;
        res_ch.ready = 1'b0;
        zero_thr = vau_pkg::ZERO_THR_RST;
        mismatches = 0;
        checked = 0;
        rx_quiet = 1'b0;
        rx_hold = 1'b0;
        tx_quiet = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_threshold_settings();
        test_backpressure();
        test_random_stream();
        drain_pipeline();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/vau_pkg.sv
rtl/vau_if.sv
rtl/vau_lane.sv
rtl/vau_isqrt.sv
rtl/vau_div.sv
rtl/vector3_arithmetic_unit.sv
dv/tb_vector3_arithmetic_unit.sv
